>>> hw/rtl/utf8_strict_terminated_check_core_macros.svh
// Assertion macros shared by the RTL of the UTF-8 checker.
`ifndef UTF8_STRICT_TERMINATED_CHECK_CORE_MACROS_SVH
`define UTF8_STRICT_TERMINATED_CHECK_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define UTF8STC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that post holds in the cycle after pre.
`define UTF8STC_ASSERT_NEXT(label, pre, post, msg) \
  `UTF8STC_ASSERT(label, pre |=> post, msg)

`endif

>>> hw/rtl/utf8stc_pkg.sv
package utf8stc_pkg;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_TERM   = 3'd1;
  localparam logic [2:0] ERR_BAD_LEAD  = 3'd2;
  localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
  localparam logic [2:0] ERR_OVERLONG  = 3'd4;
  localparam logic [2:0] ERR_SURROGATE = 3'd5;
  localparam logic [2:0] ERR_ABOVE_MAX = 3'd6;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR  = 2'd3;

  localparam logic [20:0] CP_MIN_TWO   = 21'h000080;
  localparam logic [20:0] CP_MIN_THREE = 21'h000800;
  localparam logic [20:0] CP_MIN_FOUR  = 21'h010000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;

  localparam logic [7:0] LEN_MAX = 8'hFF;

  // Decoder state carried from one byte to the next
  typedef struct packed {
    logic [1:0]  pend;
    logic [20:0] cp;
    logic [1:0]  cls;
    logic        term;
    logic [2:0]  err;
    logic [7:0]  len;
  } state_t;

endpackage

>>> hw/rtl/utf8stc_step.sv
module utf8stc_step (
  input  utf8stc_pkg::state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                en_i,
  output utf8stc_pkg::state_t state_o
);

  logic [20:0] cp_ext;
  logic [20:0] cp_min;
  logic [2:0]  fin_err;

  assign cp_ext = {state_i.cp[14:0], byte_i[5:0]};

  always_comb begin
    case (state_i.cls)
      utf8stc_pkg::CLS_TWO:   cp_min = utf8stc_pkg::CP_MIN_TWO;
      utf8stc_pkg::CLS_THREE: cp_min = utf8stc_pkg::CP_MIN_THREE;
      default:                cp_min = utf8stc_pkg::CP_MIN_FOUR;
    endcase
  end

  // Overlong first, then range, then surrogate
  always_comb begin
    if (cp_ext < cp_min) begin
      fin_err = utf8stc_pkg::ERR_OVERLONG;
    end else if (cp_ext > utf8stc_pkg::CP_MAX) begin
      fin_err = utf8stc_pkg::ERR_ABOVE_MAX;
    end else if (cp_ext >= utf8stc_pkg::SURR_LO && cp_ext <= utf8stc_pkg::SURR_HI) begin
      fin_err = utf8stc_pkg::ERR_SURROGATE;
    end else begin
      fin_err = utf8stc_pkg::ERR_NONE;
    end
  end

  always_comb begin
    state_o = state_i;
    if (en_i) begin
      if (byte_i == 8'h00) begin
        state_o.term = 1'b1;
        if (state_i.pend != 2'd0 && state_i.err == utf8stc_pkg::ERR_NONE) begin
          state_o.err = utf8stc_pkg::ERR_BAD_CONT;
        end
        state_o.pend = 2'd0;
      end else begin
        if (state_i.len != utf8stc_pkg::LEN_MAX) begin
          state_o.len = state_i.len + 8'd1;
        end
        if (state_i.err == utf8stc_pkg::ERR_NONE) begin
          if (state_i.pend != 2'd0) begin
            if (byte_i[7:6] != 2'b10) begin
              state_o.err  = utf8stc_pkg::ERR_BAD_CONT;
              state_o.pend = 2'd0;
            end else if (state_i.pend == 2'd1) begin
              // last continuation: close the sequence
              state_o.err  = fin_err;
              state_o.pend = 2'd0;
              state_o.cls  = utf8stc_pkg::CLS_NONE;
              state_o.cp   = 21'd0;
            end else begin
              state_o.cp   = cp_ext;
              state_o.pend = state_i.pend - 2'd1;
            end
          end else if (byte_i[7] == 1'b0) begin
            state_o.pend = 2'd0;
          end else if (byte_i[7:5] == 3'b110) begin
            state_o.cls  = utf8stc_pkg::CLS_TWO;
            state_o.pend = 2'd1;
            state_o.cp   = {16'd0, byte_i[4:0]};
          end else if (byte_i[7:4] == 4'b1110) begin
            state_o.cls  = utf8stc_pkg::CLS_THREE;
            state_o.pend = 2'd2;
            state_o.cp   = {17'd0, byte_i[3:0]};
          end else if (byte_i[7:3] == 5'b11110) begin
            state_o.cls  = utf8stc_pkg::CLS_FOUR;
            state_o.pend = 2'd3;
            state_o.cp   = {18'd0, byte_i[2:0]};
          end else begin
            state_o.err = utf8stc_pkg::ERR_BAD_LEAD;
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/utf8_strict_terminated_check_core.sv
// Streaming strict UTF-8 check of a NUL-terminated buffer. One byte enters per
// item and one item can be accepted in every cycle while the input does not
// stall. The final byte sits in the input register, and its verdict is loaded
// into the result register when that byte advances. The throughput of one byte
// per cycle is set by the decoder state update, which is combinational from the
// input register. A final byte is held in the input register while an earlier
// result is still waiting to be taken, and the input stalls for that time. Only
// the first MAX_BYTES bytes of a buffer are examined; a NUL after them counts
// as no terminator. One result item is produced per buffer, on its final byte.
`include "utf8_strict_terminated_check_core_macros.svh"

module utf8_strict_terminated_check_core #(
  parameter int unsigned MAX_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [7:0] text_length_o,
  output logic [2:0] error_kind_o
);

  localparam int unsigned PosW = $clog2(MAX_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_BYTES);

  logic                stg_valid_q;
  logic [7:0]          stg_byte_q;
  logic                stg_final_q;
  logic                stg_adv;
  logic                in_acc;
  logic                examine;
  logic [PosW-1:0]     pos_q;
  logic [PosW-1:0]     pos_d;
  utf8stc_pkg::state_t state_q;
  utf8stc_pkg::state_t state_d;
  utf8stc_pkg::state_t step_st;
  logic                out_valid_q;
  logic                res_valid_q;
  logic [7:0]          res_len_q;
  logic [2:0]          res_err_q;

  // a final byte waits while the result register is still occupied
  assign stg_adv    = stg_valid_q && (!stg_final_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || stg_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign examine    = (pos_q < PosMax) && !state_q.term;

  utf8stc_step u_step (
    .state_i (state_q),
    .byte_i  (stg_byte_q),
    .en_i    (examine),
    .state_o (step_st)
  );

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    if (stg_adv) begin
      if (stg_final_q) begin
        state_d = '0;
        pos_d   = '0;
      end else begin
        state_d = step_st;
        if (pos_q < PosMax) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      state_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        stg_valid_q <= 1'b1;
      end else if (stg_adv) begin
        stg_valid_q <= 1'b0;
      end
      state_q <= state_d;
      pos_q   <= pos_d;
      if (stg_adv && stg_final_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_byte_q  <= data_byte_i;
      stg_final_q <= is_final_i;
    end
    if (stg_adv && stg_final_q) begin
      if (!step_st.term) begin
        res_valid_q <= 1'b0;
        res_len_q   <= 8'd0;
        res_err_q   <= utf8stc_pkg::ERR_NO_TERM;
      end else begin
        res_valid_q <= (step_st.err == utf8stc_pkg::ERR_NONE);
        res_len_q   <= step_st.len;
        res_err_q   <= step_st.err;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = res_valid_q;
  assign text_length_o = res_len_q;
  assign error_kind_o  = res_err_q;

  `UTF8STC_ASSERT(a_pass_no_err,
    out_valid_o && valid_res_o |-> error_kind_o == utf8stc_pkg::ERR_NONE,
    "pass verdict with an error code")
  `UTF8STC_ASSERT(a_noterm_len,
    out_valid_o && error_kind_o == utf8stc_pkg::ERR_NO_TERM |-> text_length_o == 8'd0,
    "length set without terminator")
  `UTF8STC_ASSERT_NEXT(a_clear, stg_adv && stg_final_q,
    state_q == '0 && pos_q == '0,
    "state not cleared after final item")
  `UTF8STC_ASSERT(a_pend_cls,
    state_q.pend != 2'd0 |-> state_q.cls != 2'd0 && state_q.pend <= state_q.cls,
    "pending count beyond sequence class")
  `UTF8STC_ASSERT(a_err_idle,
    state_q.err != utf8stc_pkg::ERR_NONE |-> state_q.pend == 2'd0,
    "decoding continues after error")

endmodule
